>>> rtl/dc_motor_slew_pwm_drive_defines.svh
// Assertion macros for the motor drive RTL.
`ifndef DC_MOTOR_SLEW_PWM_DRIVE_DEFINES_SVH
`define DC_MOTOR_SLEW_PWM_DRIVE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dcm_pkg.sv
// Types, constants and the duty function of the motor drive.
package dcm_pkg;

    // Fixed-point format and PWM range of the bridge.
    localparam int PWM_MAX   = 255;
    localparam int FRAC_BITS = 8;
    localparam int DUTY_LIM  = (PWM_MAX > 255) ? 255 : PWM_MAX;
    localparam logic [17:0] DUTY_HALF = 18'((1 << FRAC_BITS) >> 1);

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [2:0] REG_VELOCITY_MAX    = 3'd0;
    localparam logic [2:0] REG_ACCEL_STEP      = 3'd1;
    localparam logic [2:0] REG_DRIVER_MODEL    = 3'd2;
    localparam logic [2:0] REG_IN1_ACTIVE_HIGH = 3'd3;
    localparam logic [2:0] REG_IN2_ACTIVE_HIGH = 3'd4;
    localparam logic [2:0] REG_FAULT_MODE      = 3'd5;

    // Bridge driver styles.
    localparam logic DRV_TWO_PWM = 1'b0;
    localparam logic DRV_DIR_PWM = 1'b1;

    // Fault line decoding.
    localparam logic [1:0] FAULT_OFF    = 2'd0;
    localparam logic [1:0] FAULT_LOW    = 2'd1;
    localparam logic [1:0] FAULT_HIGH   = 2'd2;
    localparam logic [1:0] FAULT_UNUSED = 2'd3;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [15:0] velocity_max;
        logic [15:0] accel_step;
        logic        driver_model;
        logic        in1_active_high;
        logic        in2_active_high;
        logic [1:0]  fault_mode;
    } cfg_t;

    // Round a Q.FRAC_BITS value half up to whole counts, capped at DUTY_LIM; negatives give 0.
    function automatic logic [7:0] to_duty(input logic signed [17:0] q);
        logic [17:0] sum;
        logic [17:0] whole;
        sum   = {1'b0, q[16:0]} + DUTY_HALF;
        whole = sum >> FRAC_BITS;
        if (q[17]) begin
            return 8'd0;
        end else if (whole > 18'(DUTY_LIM)) begin
            return 8'(DUTY_LIM);
        end else begin
            return whole[7:0];
        end
    endfunction

endpackage

>>> rtl/dcm_regs.sv
// APB register file holding the drive configuration.
module dcm_regs
    import dcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes on the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.velocity_max    <= 16'd65280;
            cfg_reg.accel_step      <= 16'd256;
            cfg_reg.driver_model    <= DRV_TWO_PWM;
            cfg_reg.in1_active_high <= 1'b0;
            cfg_reg.in2_active_high <= 1'b0;
            cfg_reg.fault_mode      <= FAULT_OFF;
        end else if (wr_en) begin
            case (reg_idx)
                REG_VELOCITY_MAX:    cfg_reg.velocity_max    <= pwdata[15:0];
                REG_ACCEL_STEP:      cfg_reg.accel_step      <= pwdata[15:0];
                REG_DRIVER_MODEL:    cfg_reg.driver_model    <= pwdata[0];
                REG_IN1_ACTIVE_HIGH: cfg_reg.in1_active_high <= pwdata[0];
                REG_IN2_ACTIVE_HIGH: cfg_reg.in2_active_high <= pwdata[0];
                REG_FAULT_MODE:      cfg_reg.fault_mode      <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Read mux; unmapped addresses read as zero.
    always_comb begin
        case (reg_idx)
            REG_VELOCITY_MAX:    prdata = {16'd0, cfg_reg.velocity_max};
            REG_ACCEL_STEP:      prdata = {16'd0, cfg_reg.accel_step};
            REG_DRIVER_MODEL:    prdata = {31'd0, cfg_reg.driver_model};
            REG_IN1_ACTIVE_HIGH: prdata = {31'd0, cfg_reg.in1_active_high};
            REG_IN2_ACTIVE_HIGH: prdata = {31'd0, cfg_reg.in2_active_high};
            REG_FAULT_MODE:      prdata = {30'd0, cfg_reg.fault_mode};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/dc_motor_slew_pwm_drive.sv
// Top level: slew-limited velocity and H-bridge PWM duties per control tick.
//
//  Port group   Direction  Beat contents
//  s_axis_*     in         target velocity, enable flag, fault pin level
//  m_axis_*     out        velocity, direction, bridge duties and levels, fault
//  APB          in/out     six configuration registers at byte addresses 0..20
//
// One beat per clock cycle is sustained while m_axis_tready is high; a beat
// passes through the input register, then the result register. The kept
// velocity feeds back through a single register, so consecutive ticks follow
// without waiting. Reset is synchronous and clears the valid flags and the
// kept velocity. A stalled result holds in the result register while the
// input register still takes one more beat.
`include "dc_motor_slew_pwm_drive_defines.svh"

module dc_motor_slew_pwm_drive
    import dcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // [16:0] target_velocity, [17] drive_enabled, [18] fault_pin, [23:19] zero
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [16:0] present_velocity, [17] reverse, [25:18] pin1_duty, [26] pin1_level,
    // [34:27] pin2_duty, [35] fault, [39:36] zero
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;

    logic        in_valid_reg;
    logic [18:0] in_data_reg;
    logic        out_valid_reg;
    logic [35:0] out_data_reg;
    logic [16:0] velocity_reg;

    logic        in_load;
    logic        out_load;

    logic signed [17:0] vmax_s;
    logic signed [17:0] target_raw;
    logic signed [17:0] target_clamp;
    logic signed [18:0] vel_old;
    logic signed [18:0] target_w;
    logic signed [18:0] step_w;
    logic signed [18:0] vel_up;
    logic signed [18:0] vel_down;
    logic signed [18:0] vel_new;
    logic [16:0]        velocity_next;
    logic               rev;
    logic [16:0]        vel_neg;
    logic [15:0]        power;
    logic signed [17:0] power_s;
    logic signed [17:0] inv_power;
    logic [7:0]         duty_idle;
    logic [7:0]         duty1_src;
    logic [7:0]         duty2_src;
    logic [7:0]         duty1;
    logic [7:0]         duty2;
    logic               level1;
    logic               fault;

    dcm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: each stage takes a beat when it is empty or drains this cycle.
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            velocity_reg  <= 17'd0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                velocity_reg  <= velocity_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_axis_tdata[18:0];
        end
        if (out_load) begin
            out_data_reg <= {fault, duty2, level1, duty1, rev, velocity_next};
        end
    end

    // Target: zero when disabled, then clamped to plus or minus the maximum.
    assign vmax_s     = signed'({2'b00, cfg.velocity_max});
    assign target_raw = in_data_reg[17] ? 18'(signed'(in_data_reg[16:0])) : 18'sd0;

    always_comb begin
        if (target_raw > vmax_s) begin
            target_clamp = vmax_s;
        end else if (target_raw < -vmax_s) begin
            target_clamp = -vmax_s;
        end else begin
            target_clamp = target_raw;
        end
    end

    // Slew limiter: step toward the target without passing it.
    assign vel_old  = 19'(signed'(velocity_reg));
    assign target_w = 19'(target_clamp);
    assign step_w   = signed'({3'b000, cfg.accel_step});
    assign vel_up   = vel_old + step_w;
    assign vel_down = vel_old - step_w;

    always_comb begin
        if (target_w > vel_old) begin
            vel_new = (vel_up > target_w) ? target_w : vel_up;
        end else if (target_w < vel_old) begin
            vel_new = (vel_down < target_w) ? target_w : vel_down;
        end else begin
            vel_new = vel_old;
        end
    end

    assign velocity_next = vel_new[16:0];

    // Direction and magnitude of the new velocity.
    assign rev       = velocity_next[16];
    assign vel_neg   = 17'(-signed'(velocity_next));
    assign power     = rev ? vel_neg[15:0] : velocity_next[15:0];
    assign power_s   = signed'({2'b00, power});
    assign inv_power = vmax_s - power_s;

    // Bridge duties; an active-high input carries the inverted duty.
    assign duty_idle = to_duty(vmax_s);
    assign duty1_src = to_duty(cfg.in1_active_high ? inv_power : power_s);
    assign duty2_src = to_duty(cfg.in2_active_high ? inv_power : power_s);

    always_comb begin
        duty1  = 8'd0;
        duty2  = duty2_src;
        level1 = 1'b0;
        case (cfg.driver_model)
            DRV_TWO_PWM: begin
                if (!rev) begin
                    duty1 = cfg.in1_active_high ? duty_idle : 8'd0;
                    duty2 = duty2_src;
                end else begin
                    duty1 = duty1_src;
                    duty2 = cfg.in2_active_high ? duty_idle : 8'd0;
                end
            end
            DRV_DIR_PWM: begin
                level1 = cfg.in1_active_high ^ rev;
            end
            default: ;
        endcase
    end

    // Fault line decoding.
    always_comb begin
        case (cfg.fault_mode)
            FAULT_LOW:  fault = !in_data_reg[18];
            FAULT_HIGH: fault = in_data_reg[18];
            default:    fault = 1'b0;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

    // The kept velocity moves only when a result is produced.
    `DCM_ASSERT_NEXT(a_vel_hold, !out_load, $stable(velocity_reg),
        "kept velocity changed without a result")
    // An empty input stage always takes a beat.
    `DCM_ASSERT_NOW(a_ready_empty, !in_valid_reg, s_axis_tready,
        "input register empty but not ready")
    // The direction flag is the sign of the delivered velocity.
    `DCM_ASSERT_NOW(a_rev_sign, m_axis_tvalid, m_axis_tdata[17] == m_axis_tdata[16],
        "reverse flag disagrees with velocity sign")
    // Only one of direction level and first duty can be in use.
    `DCM_ASSERT_NOW(a_mode_excl, m_axis_tvalid,
        (m_axis_tdata[26] == 1'b0) || (m_axis_tdata[25:18] == 8'd0),
        "direction level and first duty both driven")
    // An ignored fault line never flags.
    `DCM_ASSERT_NOW(a_fault_off,
        m_axis_tvalid && ((cfg.fault_mode == FAULT_OFF) || (cfg.fault_mode == FAULT_UNUSED)),
        m_axis_tdata[35] == 1'b0,
        "fault flagged while fault decoding is off")

endmodule
